>>> design/rrq_pkg.sv
package rrq_pkg;

  localparam int DEPTH   = 8;
  localparam int ID_BITS = 8;

  // fixed field widths of the stream payload
  localparam int REQ_W    = 2;
  localparam int CTX_W    = 8;
  localparam int STATUS_W = 3;
  localparam int QLEN_W   = 4;

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [CTX_W-1:0] ID_MASK = CTX_W'((64'd1 << ID_BITS) - 64'd1);

  // request kinds
  localparam logic [REQ_W-1:0] REQ_REGISTER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET_CUR  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_YIELD    = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOYIELD = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [CTX_W-1:0] ctx_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                switched;
    logic [CTX_W-1:0]    prev_id;
    logic [CTX_W-1:0]    cur_id;
    logic [QLEN_W-1:0]   queue_len;
  } result_t;

endpackage

>>> design/rrq_in_stage.sv
module rrq_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rrq_pkg::req_t in_req,
  input  logic          take,
  output logic          req_valid,
  output rrq_pkg::req_t req
);

  logic          valid_r;
  logic          valid_nxt;
  rrq_pkg::req_t req_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_req;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

>>> design/rrq_core.sv
module rrq_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  rrq_pkg::req_t    req,
  output rrq_pkg::result_t result
);

  logic [rrq_pkg::CTX_W-1:0]  slot_r [rrq_pkg::DEPTH];
  logic [rrq_pkg::CNT_W-1:0]  count_r;
  logic [rrq_pkg::CNT_W-1:0]  count_nxt;
  logic [rrq_pkg::SLOT_W-1:0] cur_slot_r;
  logic [rrq_pkg::SLOT_W-1:0] cur_slot_nxt;
  logic                       cur_valid_r;
  logic                       cur_valid_nxt;
  logic [rrq_pkg::CTX_W-1:0]  cur_id_r;
  logic [rrq_pkg::CTX_W-1:0]  cur_id_nxt;

  logic [rrq_pkg::CTX_W-1:0]    id;
  logic [rrq_pkg::DEPTH-1:0]    hit;
  logic                         found;
  logic [rrq_pkg::SLOT_W-1:0]   hit_slot;
  logic                         full;
  logic [rrq_pkg::SLOT_W-1:0]   app_slot;
  logic [rrq_pkg::SLOT_W-1:0]   next_slot;
  logic                         append;
  logic [rrq_pkg::STATUS_W-1:0] status;
  logic                         switched;

  assign id       = req.ctx_id & rrq_pkg::ID_MASK;
  assign full     = (count_r == rrq_pkg::CNT_W'(rrq_pkg::DEPTH));
  assign app_slot = count_r[rrq_pkg::SLOT_W-1:0];

  // parallel compare over the filled slots
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < rrq_pkg::DEPTH; i++) begin
      hit[i] = (rrq_pkg::CNT_W'(i) < count_r) && (slot_r[i] == id);
      if (hit[i]) begin
        hit_slot = rrq_pkg::SLOT_W'(i);
      end
    end
  end
  assign found = |hit;

  // round-robin successor, wrapping after the last filled slot
  assign next_slot = (rrq_pkg::CNT_W'(cur_slot_r) == count_r - rrq_pkg::CNT_W'(1)) ?
                     '0 : cur_slot_r + rrq_pkg::SLOT_W'(1);

  always_comb begin
    status        = rrq_pkg::ST_DONE;
    switched      = 1'b0;
    append        = 1'b0;
    count_nxt     = count_r;
    cur_slot_nxt  = cur_slot_r;
    cur_valid_nxt = cur_valid_r;
    cur_id_nxt    = cur_id_r;
    case (req.req_type)
      rrq_pkg::REQ_REGISTER: begin
        if (id == '0) begin
          status = rrq_pkg::ST_NULL;
        end else if (full) begin
          status = rrq_pkg::ST_FULL;
        end else if (found) begin
          status = rrq_pkg::ST_PRESENT;
        end else begin
          append    = 1'b1;
          count_nxt = count_r + rrq_pkg::CNT_W'(1);
          if (!cur_valid_r) begin
            cur_valid_nxt = 1'b1;
            cur_slot_nxt  = app_slot;
            cur_id_nxt    = id;
          end
        end
      end
      rrq_pkg::REQ_SET_CUR: begin
        if (id == '0) begin
          status = rrq_pkg::ST_NULL;
        end else if (found) begin
          cur_valid_nxt = 1'b1;
          cur_slot_nxt  = hit_slot;
          cur_id_nxt    = id;
        end else if (!full) begin
          append        = 1'b1;
          count_nxt     = count_r + rrq_pkg::CNT_W'(1);
          cur_valid_nxt = 1'b1;
          cur_slot_nxt  = app_slot;
          cur_id_nxt    = id;
        end else begin
          status = rrq_pkg::ST_FULL;
        end
      end
      rrq_pkg::REQ_YIELD: begin
        // ids are distinct, so a valid successor always differs from current
        if (count_r <= rrq_pkg::CNT_W'(1) || !cur_valid_r) begin
          status = rrq_pkg::ST_NOYIELD;
        end else begin
          cur_slot_nxt = next_slot;
          cur_id_nxt   = slot_r[next_slot];
          switched     = 1'b1;
        end
      end
      default: begin
        // unused kind: no change
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
      cur_id_r    <= '0;
    end else if (fire) begin
      count_r     <= count_nxt;
      cur_slot_r  <= cur_slot_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_id_r    <= cur_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rrq_pkg::DEPTH; i++) begin
      if (fire && append && app_slot == rrq_pkg::SLOT_W'(i)) begin
        slot_r[i] <= id;
      end
    end
  end

  assign result.status    = status;
  assign result.switched  = switched;
  assign result.prev_id   = cur_id_r;
  assign result.cur_id    = cur_id_nxt;
  assign result.queue_len = rrq_pkg::QLEN_W'(count_nxt);

endmodule

>>> design/rrq_out_stage.sv
module rrq_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  rrq_pkg::result_t result,
  input  logic             out_ready,
  output logic             can_load,
  output logic             out_valid,
  output rrq_pkg::result_t out_result
);

  logic             valid_r;
  logic             valid_nxt;
  rrq_pkg::result_t result_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

>>> design/round_robin_runqueue_unit.sv
// channel  | direction | payload                          | transaction when
// ---------+-----------+----------------------------------+---------------------------
// in_      | slave     | tuser req_type, tdata ctx_id     | in_tvalid && in_tready
// out_     | master    | tuser status/switched, tdata ids | out_tvalid && out_tready
//
// one request per cycle sustained while out_tready is high; a result is presented once its
// request has passed the input register, then the decision logic into the result register
// the parallel id compare and wrap increment sit between the two registers
// rst_n is synchronous, active low; it empties the queue and clears current
// a stalled output holds the result and the queued request, in_tready drops
// only when both registers are full and out_tready is low
module round_robin_runqueue_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ctx_id
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] prev_id, [15:8] cur_id, [19:16] queue_len, rest 0
  output logic [3:0]  out_tuser   // [2:0] status, [3] switched
);

  rrq_pkg::req_t    in_req;
  rrq_pkg::req_t    req;
  rrq_pkg::result_t result;
  rrq_pkg::result_t out_result;
  logic             req_valid;
  logic             can_load;
  logic             fire;

  assign in_req.req_type = in_tuser;
  assign in_req.ctx_id   = in_tdata;

  // a queued request is decided when the result register can take it
  assign fire = req_valid && can_load;

  rrq_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_req),
    .take      (fire),
    .req_valid (req_valid),
    .req       (req)
  );

  // queue state and single-pass decision
  rrq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .req    (req),
    .result (result)
  );

  rrq_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .result     (result),
    .out_ready  (out_tready),
    .can_load   (can_load),
    .out_valid  (out_tvalid),
    .out_result (out_result)
  );

  // pack result fields, lowest field first
  assign out_tdata = {4'd0, out_result.queue_len, out_result.cur_id, out_result.prev_id};
  assign out_tuser = {out_result.switched, out_result.status};

endmodule
